/* sv/adrss_pkg.sv */
// ----------------------------------------------------------------------------
// adrss_pkg
// Shared constants, stage types and elaboration-time helpers for the affine
// decomposition pipeline (CORDIC gain, arctangent table).
// ----------------------------------------------------------------------------
package adrss_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 20;

    localparam int GUARD    = 16;              // guard bits ahead of the CORDIC
    localparam int ANG_FRAC = 30;              // angle fraction bits
    localparam int CSH      = ANG_FRAC + GUARD;
    localparam int CW       = 52;              // CORDIC datapath width
    localparam int ZW       = 35;              // angle accumulator width
    localparam int KW       = 31;              // inverse gain width
    localparam int SW       = 40;              // compensated value width
    localparam int DMW      = 34;              // divider operand magnitude width
    localparam int RW       = DMW + 1;         // divider remainder width
    localparam int QW       = 32;              // quotient bits produced
    localparam int AW       = 19;              // angle output width
    localparam int MHW      = CW - 32;
    localparam int PLW      = 32 + KW;
    localparam int PHW      = MHW + KW;
    localparam int SUMW     = CW + KW + 1;

    localparam logic signed [ZW-1:0] PI_Q30  = 35'sd3373259426;
    localparam logic signed [SW-1:0] S32_MAX = 40'sd2147483647;
    localparam logic signed [SW-1:0] S32_MIN = -40'sd2147483648;

    typedef struct packed {
        logic [31:0] tx;
        logic [31:0] ty;
    } t_pass;

    // CORDIC stage payload
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
        logic signed [ZW-1:0] z;
        logic                 zero;
        logic [31:0]          a12;
        logic [31:0]          a22;
        t_pass                p;
    } t_cs;

    // gain multiply partial products
    typedef struct packed {
        logic [2:0]           sg;
        logic [2:0][PLW-1:0]  pl;
        logic [2:0][PHW-1:0]  ph;
        logic [AW-1:0]        ang;
        logic                 zero;
        logic [31:0]          a12;
        logic [31:0]          a22;
        t_pass                p;
    } t_ms;

    // compensated results
    typedef struct packed {
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] msy;
        logic signed [SW-1:0] sy;
        logic [AW-1:0]        ang;
        t_pass                p;
    } t_cr;

    // divider stage payload
    typedef struct packed {
        logic [RW-1:0]        rem;
        logic [QW-1:0]        nlo;
        logic [QW-1:0]        q;
        logic [DMW-1:0]       dm;
        logic                 ovf;
        logic                 neg;
        logic                 sing;
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic [AW-1:0]        ang;
        t_pass                p;
    } t_ds;

    // atan(2^-i), Q30; truncated through index 26, rounded above it
    function automatic logic [31:0] f_atan(input int idx);
        case (idx)
            0:  return 32'h3243F6A8;
            1:  return 32'h1DAC6705;
            2:  return 32'h0FADBAFC;
            3:  return 32'h07F56EA6;
            4:  return 32'h03FEAB76;
            5:  return 32'h01FFD55B;
            6:  return 32'h00FFFAAA;
            7:  return 32'h007FFF55;
            8:  return 32'h003FFFEA;
            9:  return 32'h001FFFFD;
            10: return 32'h000FFFFF;
            11: return 32'h0007FFFF;
            12: return 32'h0003FFFF;
            13: return 32'h0001FFFF;
            14: return 32'h0000FFFF;
            15: return 32'h00007FFF;
            16: return 32'h00003FFF;
            17: return 32'h00001FFF;
            18: return 32'h00000FFF;
            19: return 32'h000007FF;
            20: return 32'h000003FF;
            21: return 32'h000001FF;
            22: return 32'h000000FF;
            23: return 32'h0000007F;
            24: return 32'h0000003F;
            25: return 32'h0000001F;
            26: return 32'h0000000F;
            27: return 32'h00000008;
            28: return 32'h00000004;
            29: return 32'h00000002;
            30: return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

    // round(2^30 / sqrt(prod(1 + 2^-2i))), Q30; elaboration only
    function automatic logic [KW-1:0] f_inv_gain(input int stages);
        logic [63:0] k2;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        k2 = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (i < stages) k2 = k2 + (k2 >> (2 * i));
        end
        n = k2;
        r = '0;
        b = 64'h1 << 62;
        for (int t = 0; t < 32; t++) begin
            if (b > n) b = b >> 2;
        end
        for (int t = 0; t < 32; t++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        num = (64'h1 << 61) + (r >> 1);
        rem = '0;
        q   = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[62:0], num[j]};
            if (rem >= r) begin
                rem  = rem - r;
                q[j] = 1'b1;
            end
        end
        return q[KW-1:0];
    endfunction

endpackage

/* sv/affine_decompose_rotation_scale_shear_top.sv */
// ----------------------------------------------------------------------------
// affine_decompose_rotation_scale_shear_top
// Splits a 2x3 Q15.16 affine matrix into translation, rotation, scales and
// shear with an unrolled vectoring CORDIC and a pipelined radix-2 divider.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+---------------------
//  request   | i_trans_x/y, i_elem_a11/a12/a21/a22      | start & !busy
//  result    | o_out_trans_x/y, o_rot_angle, o_scale_x, | o_done, 1 cycle
//            | o_scale_y, o_shear, o_singular, o_clamped|
//
//  One request per cycle; busy stays low. A result passes the input
//  register, one stage per CORDIC micro-rotation, two for gain
//  compensation, two for divider setup, one per quotient bit (32) and
//  one output register. Synchronous active-low reset clears all
//  valid bits; requests in flight are dropped.
// ----------------------------------------------------------------------------
module affine_decompose_rotation_scale_shear_top
    import adrss_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    i_trans_x,
    input  logic signed [31:0]    i_trans_y,
    input  logic signed [31:0]    i_elem_a11,
    input  logic signed [31:0]    i_elem_a12,
    input  logic signed [31:0]    i_elem_a21,
    input  logic signed [31:0]    i_elem_a22,
    output logic                  o_done,
    output logic signed [31:0]    o_out_trans_x,
    output logic signed [31:0]    o_out_trans_y,
    output logic signed [AW-1:0]  o_rot_angle,
    output logic [30:0]           o_scale_x,
    output logic signed [31:0]    o_scale_y,
    output logic signed [31:0]    o_shear,
    output logic                  o_singular,
    output logic                  o_clamped
);

    localparam int P_LATENCY = CORDIC_STAGES + 38;
    localparam int NW = DMW + FRAC_BITS + 1;
    localparam int SH = ANG_FRAC - FRAC_BITS;
    localparam logic [KW-1:0]        KINV   = f_inv_gain(CORDIC_STAGES);
    localparam logic signed [ZW-1:0] HALF   = ZW'(1) <<< (SH - 1);
    localparam logic signed [ZW-1:0] PI_OUT = (PI_Q30 + HALF) >>> SH;

    typedef struct packed {
        logic [NW-1:0]        n;
        logic [DMW-1:0]       dm;
        logic                 neg;
        logic                 sing;
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic [AW-1:0]        ang;
        t_pass                p;
    } t_d0;

    assign busy = 1'b0;

    // ---------------- input stage ----------------
    t_cs                   r_cs [CORDIC_STAGES+1];
    t_cs                   n_cs [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0] r_vc;

    always_comb begin
        logic signed [CW-1:0] x0, y0, u0, v0;
        x0 = {{(CW-32-GUARD){i_elem_a11[31]}}, i_elem_a11, {GUARD{1'b0}}};
        y0 = {{(CW-32-GUARD){i_elem_a21[31]}}, i_elem_a21, {GUARD{1'b0}}};
        u0 = {{(CW-32-GUARD){i_elem_a12[31]}}, i_elem_a12, {GUARD{1'b0}}};
        v0 = {{(CW-32-GUARD){i_elem_a22[31]}}, i_elem_a22, {GUARD{1'b0}}};
        n_cs[0].zero = (i_elem_a11 == '0) && (i_elem_a21 == '0);
        n_cs[0].a12  = i_elem_a12;
        n_cs[0].a22  = i_elem_a22;
        n_cs[0].p.tx = i_trans_x;
        n_cs[0].p.ty = i_trans_y;
        // left half plane: flip both vectors, start from +-pi
        if (i_elem_a11[31]) begin
            n_cs[0].x = -x0;
            n_cs[0].y = -y0;
            n_cs[0].u = -u0;
            n_cs[0].v = -v0;
            n_cs[0].z = i_elem_a21[31] ? -PI_Q30 : PI_Q30;
        end else begin
            n_cs[0].x = x0;
            n_cs[0].y = y0;
            n_cs[0].u = u0;
            n_cs[0].v = v0;
            n_cs[0].z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc[0] <= 1'b0;
        end else begin
            r_vc[0] <= start & ~busy;
        end
        r_cs[0] <= n_cs[0];
    end

    // ---------------- CORDIC micro-rotations ----------------
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
        always_comb begin
            logic signed [CW-1:0] xs, ys, us, vs;
            logic signed [ZW-1:0] at;
            xs = r_cs[gi].x >>> gi;
            ys = r_cs[gi].y >>> gi;
            us = r_cs[gi].u >>> gi;
            vs = r_cs[gi].v >>> gi;
            at = $signed(ZW'(f_atan(gi)));
            n_cs[gi+1] = r_cs[gi];
            if (!r_cs[gi].y[CW-1]) begin
                n_cs[gi+1].x = r_cs[gi].x + ys;
                n_cs[gi+1].y = r_cs[gi].y - xs;
                n_cs[gi+1].u = r_cs[gi].u + vs;
                n_cs[gi+1].v = r_cs[gi].v - us;
                n_cs[gi+1].z = r_cs[gi].z + at;
            end else begin
                n_cs[gi+1].x = r_cs[gi].x - ys;
                n_cs[gi+1].y = r_cs[gi].y + xs;
                n_cs[gi+1].u = r_cs[gi].u - vs;
                n_cs[gi+1].v = r_cs[gi].v + us;
                n_cs[gi+1].z = r_cs[gi].z - at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vc[gi+1] <= 1'b0;
            end else begin
                r_vc[gi+1] <= r_vc[gi];
            end
            r_cs[gi+1] <= n_cs[gi+1];
        end
    end

    // ---------------- gain multiply, angle rounding ----------------
    t_ms  r_ms, n_ms;
    logic r_vm;

    always_comb begin
        logic signed [CW-1:0] val;
        logic [CW-1:0]        mag;
        logic signed [ZW-1:0] af;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0:       val = r_cs[CORDIC_STAGES].x;
                1:       val = r_cs[CORDIC_STAGES].u;
                default: val = r_cs[CORDIC_STAGES].v;
            endcase
            n_ms.sg[k] = val[CW-1];
            mag        = val[CW-1] ? CW'(-val) : CW'(val);
            n_ms.pl[k] = PLW'(mag[31:0]) * PLW'(KINV);
            n_ms.ph[k] = PHW'(mag[CW-1:32]) * PHW'(KINV);
        end
        af = (r_cs[CORDIC_STAGES].z + HALF) >>> SH;
        if (af > PI_OUT) af = PI_OUT;
        if (af < -PI_OUT) af = -PI_OUT;
        n_ms.ang  = r_cs[CORDIC_STAGES].zero ? '0 : af[AW-1:0];
        n_ms.zero = r_cs[CORDIC_STAGES].zero;
        n_ms.a12  = r_cs[CORDIC_STAGES].a12;
        n_ms.a22  = r_cs[CORDIC_STAGES].a22;
        n_ms.p    = r_cs[CORDIC_STAGES].p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= r_vc[CORDIC_STAGES];
        end
        r_ms <= n_ms;
    end

    // ---------------- gain sum, round, sign restore ----------------
    t_cr  r_cr, n_cr;
    logic r_vr;

    always_comb begin
        logic [SUMW-1:0]      sum;
        logic signed [SW-1:0] sv [3];
        for (int k = 0; k < 3; k++) begin
            sum = (SUMW'(r_ms.ph[k]) << 32) + SUMW'(r_ms.pl[k])
                + (SUMW'(1) << (CSH - 1));
            sv[k] = $signed(SW'(sum[SUMW-1:CSH]));
            if (r_ms.sg[k]) sv[k] = -sv[k];
        end
        if (r_ms.zero) begin
            n_cr.sx  = '0;
            n_cr.msy = SW'($signed(r_ms.a12));
            n_cr.sy  = SW'($signed(r_ms.a22));
        end else begin
            n_cr.sx  = sv[0];
            n_cr.msy = sv[1];
            n_cr.sy  = sv[2];
        end
        n_cr.ang = r_ms.ang;
        n_cr.p   = r_ms.p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else begin
            r_vr <= r_vm;
        end
        r_cr <= n_cr;
    end

    // ---------------- divider numerator ----------------
    t_d0  r_d0, n_d0;
    logic r_vd;

    always_comb begin
        logic [DMW-1:0] nm;
        nm        = r_cr.msy[SW-1] ? DMW'(-r_cr.msy) : DMW'(r_cr.msy);
        n_d0.dm   = r_cr.sy[SW-1] ? DMW'(-r_cr.sy) : DMW'(r_cr.sy);
        n_d0.n    = (NW'(nm) << FRAC_BITS) + NW'(n_d0.dm >> 1);
        n_d0.neg  = r_cr.msy[SW-1] ^ r_cr.sy[SW-1];
        n_d0.sing = (r_cr.sy == '0);
        n_d0.sx   = r_cr.sx;
        n_d0.sy   = r_cr.sy;
        n_d0.ang  = r_cr.ang;
        n_d0.p    = r_cr.p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else begin
            r_vd <= r_vr;
        end
        r_d0 <= n_d0;
    end

    // ---------------- divider: overflow check, then one bit per stage ----
    t_ds         r_ds [QW+1];
    t_ds         n_ds [QW+1];
    logic [QW:0] r_vq;

    always_comb begin
        logic [NW-1:0] hi;
        hi             = r_d0.n >> QW;
        n_ds[0].ovf    = hi >= NW'(r_d0.dm);
        n_ds[0].rem    = n_ds[0].ovf ? '0 : RW'(hi);
        n_ds[0].nlo    = r_d0.n[QW-1:0];
        n_ds[0].q      = '0;
        n_ds[0].dm     = r_d0.dm;
        n_ds[0].neg    = r_d0.neg;
        n_ds[0].sing   = r_d0.sing;
        n_ds[0].sx     = r_d0.sx;
        n_ds[0].sy     = r_d0.sy;
        n_ds[0].ang    = r_d0.ang;
        n_ds[0].p      = r_d0.p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq[0] <= 1'b0;
        end else begin
            r_vq[0] <= r_vd;
        end
        r_ds[0] <= n_ds[0];
    end

    for (genvar gj = 0; gj < QW; gj++) begin : g_div
        always_comb begin
            logic [RW:0] t;
            logic [RW:0] d;
            t = {r_ds[gj].rem, r_ds[gj].nlo[QW-1-gj]};
            d = (RW+1)'(r_ds[gj].dm);
            n_ds[gj+1] = r_ds[gj];
            if (t >= d) begin
                n_ds[gj+1].rem         = RW'(t - d);
                n_ds[gj+1].q[QW-1-gj]  = 1'b1;
            end else begin
                n_ds[gj+1].rem         = RW'(t);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vq[gj+1] <= 1'b0;
            end else begin
                r_vq[gj+1] <= r_vq[gj];
            end
            r_ds[gj+1] <= n_ds[gj+1];
        end
    end

    // ---------------- saturation and output register ----------------
    logic                r_done;
    logic signed [31:0]  r_tx, r_ty, r_sy, r_sh;
    logic [AW-1:0]       r_ang;
    logic [30:0]         r_sx;
    logic                r_sing, r_clamp;
    logic signed [31:0]  n_sy, n_sh;
    logic [30:0]         n_sx;
    logic                n_clamp;

    always_comb begin
        t_ds f;
        f       = r_ds[QW];
        n_clamp = 1'b0;
        n_sh    = '0;
        if (f.sing) begin
            n_sh = '0;
        end else if (f.ovf) begin
            n_clamp = 1'b1;
            n_sh    = f.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (!f.neg) begin
            if (f.q[QW-1]) begin
                n_clamp = 1'b1;
                n_sh    = 32'sh7FFF_FFFF;
            end else begin
                n_sh = $signed(f.q);
            end
        end else begin
            if (f.q[QW-1] && (f.q[QW-2:0] != '0)) begin
                n_clamp = 1'b1;
                n_sh    = 32'sh8000_0000;
            end else begin
                n_sh = -$signed(f.q);
            end
        end
        if (f.sx > S32_MAX) begin
            n_clamp = 1'b1;
            n_sx    = '1;
        end else begin
            n_sx = f.sx[30:0];
        end
        if (f.sy > S32_MAX) begin
            n_clamp = 1'b1;
            n_sy    = 32'sh7FFF_FFFF;
        end else if (f.sy < S32_MIN) begin
            n_clamp = 1'b1;
            n_sy    = 32'sh8000_0000;
        end else begin
            n_sy = f.sy[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vq[QW];
        end
        r_tx    <= r_ds[QW].p.tx;
        r_ty    <= r_ds[QW].p.ty;
        r_ang   <= r_ds[QW].ang;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_sh    <= n_sh;
        r_sing  <= r_ds[QW].sing;
        r_clamp <= n_clamp;
    end

    assign o_done        = r_done;
    assign o_out_trans_x = r_tx;
    assign o_out_trans_y = r_ty;
    assign o_rot_angle   = r_ang;
    assign o_scale_x     = r_sx;
    assign o_scale_y     = r_sy;
    assign o_shear       = r_sh;
    assign o_singular    = r_sing;
    assign o_clamped     = r_clamp;

endmodule

/* sv/adrss_chk.sv */
// ----------------------------------------------------------------------------
// adrss_chk
// Port-level checks on the decomposition pipeline: fixed latency, ordering
// of translation pass-through, singular shear.
// ----------------------------------------------------------------------------
module adrss_chk
    import adrss_pkg::*;
#(
    parameter int P_LAT = CORDIC_STAGES_DEF + 38
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [31:0] i_trans_x,
    input logic               o_done,
    input logic signed [31:0] o_out_trans_x,
    input logic signed [31:0] o_shear,
    input logic               o_singular
);

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##P_LAT o_done)
        else $error("request not answered after fixed latency");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, P_LAT))
        else $error("result strobe without matching request");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out_trans_x == $past(i_trans_x, P_LAT)))
        else $error("translation out of order");

    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_singular) |-> (o_shear == '0))
        else $error("singular result with nonzero shear");

endmodule

bind affine_decompose_rotation_scale_shear_top adrss_chk #(.P_LAT(P_LATENCY)) u_adrss_chk (.*);

/* verif/affine_decompose_rotation_scale_shear_top_test.sv */
// ----------------------------------------------------------------------------
// affine_decompose_rotation_scale_shear_top_test
// Drives 2x3 affine matrices into the decomposition pipeline and checks the
// translation, angle, scales, shear and flags of every result. Each result is
// checked against a bit-exact fixed-point CORDIC/divider predictor, in order.
// ----------------------------------------------------------------------------
module affine_decompose_rotation_scale_shear_top_test
    import adrss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC       = 16;
    localparam int  STAGES     = 20;
    localparam int  ASH        = ANG_FRAC - FRAC;
    localparam int  LATENCY    = STAGES + 37;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  N_RANDOM   = 1030;
    localparam longint PI_Z    = 64'sd3373259426;
    localparam longint MAX32   = 64'sd2147483647;
    localparam longint MIN32   = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] tx, ty, a11, a12, a21, a22;
    } t_matrix;

    typedef struct packed {
        logic [31:0]    tx, ty;
        logic [AW-1:0]  angle;
        logic [30:0]    sx;
        logic [31:0]    sy, shear;
        logic           singular, clamped;
    } t_decomp;

    logic               i_clk, i_rst_n, start;
    logic signed [31:0] i_trans_x, i_trans_y, i_elem_a11, i_elem_a12;
    logic signed [31:0] i_elem_a21, i_elem_a22;
    logic               busy, o_done, o_singular, o_clamped;
    logic signed [31:0] o_out_trans_x, o_out_trans_y, o_scale_y, o_shear;
    logic signed [AW-1:0] o_rot_angle;
    logic [30:0]        o_scale_x;

    t_matrix pending_mats[$];
    t_decomp expected_decomps[$];
    int      n_requests, n_results, n_errors, n_singular, n_clamped, idle_cycles;
    int      burst_left, gap_left;
    bit      took;

    affine_decompose_rotation_scale_shear_top #(
        .FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)
    ) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_trans_x(i_trans_x), .i_trans_y(i_trans_y),
        .i_elem_a11(i_elem_a11), .i_elem_a12(i_elem_a12),
        .i_elem_a21(i_elem_a21), .i_elem_a22(i_elem_a22),
        .o_done(o_done), .o_out_trans_x(o_out_trans_x), .o_out_trans_y(o_out_trans_y),
        .o_rot_angle(o_rot_angle), .o_scale_x(o_scale_x), .o_scale_y(o_scale_y),
        .o_shear(o_shear), .o_singular(o_singular), .o_clamped(o_clamped)
    );

    function automatic longint unsigned cordic_inv_gain();
        longint unsigned k2, n, r, b;
        k2 = 64'h1 << 62;
        for (int i = 0; i < STAGES && i < 32; i++) k2 += k2 >> (2 * i);
        n = k2;
        r = 0;
        b = 64'h1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return ((64'h1 << 61) + (r >> 1)) / r;
    endfunction

    longint unsigned inv_k;

    function automatic longint apply_gain(longint val);
        longint unsigned mag, lo, mid;
        mag = val < 0 ? -val : val;
        lo  = (mag & 64'hFFFF_FFFF) * inv_k + (64'h1 << 45);
        mid = (mag >> 32) * inv_k + (lo >> 32);
        return val < 0 ? -longint'(mid >> 14) : longint'(mid >> 14);
    endfunction

    function automatic longint clip32(longint val, ref bit flag);
        if (val > MAX32) begin flag = 1; return MAX32; end
        if (val < MIN32) begin flag = 1; return MIN32; end
        return val;
    endfunction

    function automatic t_decomp decompose(t_matrix m);
        t_decomp d;
        longint x, y, u, v, z, xs, ys, us, vs, sx, msy, sy, ang, lim, shr;
        longint unsigned nm, dm, q;
        bit clip;
        clip = 0;
        shr  = 0;
        ang  = 0;
        if (m.a11 == 0 && m.a21 == 0) begin
            sx  = 0;
            msy = m.a12;
            sy  = m.a22;
        end else begin
            x = longint'(m.a11) * 65536;
            y = longint'(m.a21) * 65536;
            u = longint'(m.a12) * 65536;
            v = longint'(m.a22) * 65536;
            z = 0;
            if (x < 0) begin
                x = -x; y = -y; u = -u; v = -v;
                z = m.a21 >= 0 ? PI_Z : -PI_Z;
            end
            for (int i = 0; i < STAGES && i < 32; i++) begin
                xs = x >>> i; ys = y >>> i; us = u >>> i; vs = v >>> i;
                if (y >= 0) begin
                    x += ys; y -= xs; u += vs; v -= us; z += longint'(f_atan(i));
                end else begin
                    x -= ys; y += xs; u -= vs; v += us; z -= longint'(f_atan(i));
                end
            end
            sx  = apply_gain(x);
            msy = apply_gain(u);
            sy  = apply_gain(v);
            lim = (PI_Z + (64'sd1 << (ASH - 1))) >>> ASH;
            ang = (z + (64'sd1 << (ASH - 1))) >>> ASH;
            if (ang > lim) ang = lim;
            if (ang < -lim) ang = -lim;
        end
        d.singular = (sy == 0);
        if (sy != 0) begin
            nm = msy < 0 ? -msy : msy;
            dm = sy < 0 ? -sy : sy;
            q  = ((nm << FRAC) + (dm >> 1)) / dm;
            if (q > (64'h1 << 40)) q = 64'h1 << 40;
            shr = ((msy < 0) != (sy < 0)) ? -longint'(q) : longint'(q);
            shr = clip32(shr, clip);
        end
        if (sx > MAX32) begin
            sx   = MAX32;
            clip = 1;
        end
        sy = clip32(sy, clip);
        d.tx      = m.tx;
        d.ty      = m.ty;
        d.angle   = ang[AW-1:0];
        d.sx      = sx[30:0];
        d.sy      = sy[31:0];
        d.shear   = shr[31:0];
        d.clamped = clip;
        return d;
    endfunction

    function automatic logic signed [31:0] pick_elem(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: return $signed($urandom_range(0, 16)) - 8;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 0;
                    3: return 1;
                    4: return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic add_mat(input logic signed [31:0] a11, a12, a21, a22);
        t_matrix m;
        m.tx = $urandom; m.ty = $urandom;
        m.a11 = a11; m.a12 = a12; m.a21 = a21; m.a22 = a22;
        pending_mats = {pending_mats, m};
    endtask

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // driver: bursts of requests with random gaps
    always @(negedge i_clk) begin
        t_matrix m;
        if (!i_rst_n) begin
            start      <= 0;
            burst_left <= 1;
            gap_left   <= 0;
            i_trans_x  <= 0; i_trans_y <= 0;
            i_elem_a11 <= 0; i_elem_a12 <= 0;
            i_elem_a21 <= 0; i_elem_a22 <= 0;
        end else if (start && !took) begin
            // hold the request until it is taken
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 0;
        end else if (pending_mats.size() > 0) begin
            m = pending_mats.pop_front();
            i_trans_x <= m.tx; i_trans_y <= m.ty;
            i_elem_a11 <= m.a11; i_elem_a12 <= m.a12;
            i_elem_a21 <= m.a21; i_elem_a22 <= m.a22;
            start <= 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            start <= 0;
        end
    end

    // monitor: record accepted requests, check results in order
    always @(posedge i_clk) begin
        t_matrix m;
        t_decomp got, want;
        took = i_rst_n && start && !busy;
        if (took) begin
            m.tx = i_trans_x; m.ty = i_trans_y;
            m.a11 = i_elem_a11; m.a12 = i_elem_a12;
            m.a21 = i_elem_a21; m.a22 = i_elem_a22;
            expected_decomps = {expected_decomps, decompose(m)};
            n_requests++;
        end
        if (i_rst_n && o_done) begin
            got.tx = o_out_trans_x; got.ty = o_out_trans_y; got.angle = o_rot_angle;
            got.sx = o_scale_x; got.sy = o_scale_y; got.shear = o_shear;
            got.singular = o_singular; got.clamped = o_clamped;
            n_results++;
            n_singular += o_singular;
            n_clamped  += o_clamped;
            if (expected_decomps.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                want = expected_decomps.pop_front();
                if (got != want) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch on result %0d:", n_results);
                        $display("  exp tx=%h ty=%h ang=%h sx=%h sy=%h sh=%h sing=%b clmp=%b",
                                 want.tx, want.ty, want.angle, want.sx, want.sy,
                                 want.shear, want.singular, want.clamped);
                        $display("  got tx=%h ty=%h ang=%h sx=%h sy=%h sh=%h sing=%b clmp=%b",
                                 got.tx, got.ty, got.angle, got.sx, got.sy,
                                 got.shear, got.singular, got.clamped);
                    end
                end
            end
        end
        idle_cycles = (took || (i_rst_n && o_done)) ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int mode;
        inv_k = cordic_inv_gain();
        i_rst_n = 0;

        // directed corners
        add_mat(0, 0, 0, 0);                                  // zero column, singular
        add_mat(0, 32'sh0003_0000, 0, -32'sh0002_0000);       // zero column, no cordic
        add_mat(32'sh0001_0000, 0, 0, 32'sh0001_0000);        // identity
        add_mat(0, -32'sh0001_0000, 32'sh0001_0000, 0);       // +90 deg
        add_mat(-32'sh0001_0000, 0, 0, -32'sh0001_0000);      // 180 deg, angle limited at pi
        add_mat(-32'sh0001_0000, 32'sh0000_4000, 32'sh0000_8000, 32'sh0001_0000);
        add_mat(-32'sh0001_0000, 32'sh0000_4000, -32'sh0000_8000, 32'sh0001_0000);
        add_mat(32'sh8000_0000, 0, 0, 32'sh8000_0000);        // most negative
        add_mat(32'sh8000_0000, 32'sh7FFF_FFFF, -1, 32'sh8000_0000);
        add_mat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_mat(32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 0);        // x scale overflow
        add_mat(32'sh0001_0000, 32'sh7FFF_FFFF, 0, 1);        // shear overflow
        add_mat(1, 32'sh8000_0000, 0, 32'sh8000_0000);        // y scale overflow
        add_mat(1, 1, 1, 1);
        add_mat(-1, 3, 1, -2);
        add_mat(32'sh0001_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0004_0000);
        add_mat(0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000);
        add_mat(0, 32'sh7FFF_FFFF, 0, 0);                     // singular with numerator
        add_mat(-1, 0, 0, 0);
        add_mat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);

        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 3);
            add_mat(pick_elem(mode), pick_elem(mode), pick_elem(mode), pick_elem(mode));
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        while (pending_mats.size() > 0 || start) @(posedge i_clk);
        while (expected_decomps.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("%0d matrices decomposed, %0d results checked, %0d singular, %0d clamped",
                 n_requests, n_results, n_singular, n_clamped);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* affine_decompose_rotation_scale_shear_top.f */
sv/adrss_pkg.sv
sv/affine_decompose_rotation_scale_shear_top.sv
sv/adrss_chk.sv
verif/affine_decompose_rotation_scale_shear_top_test.sv
